### design/gnsg_pkg.sv
// shared types, constants and helper functions of the neighbour stencil generator
package gnsg_pkg;

  localparam int AXIS_MAX    = 64;
  localparam int AXIS_W      = $clog2(AXIS_MAX + 1);
  localparam int COORD_W     = 6;
  localparam int INDEX_W     = 18;
  localparam int SLOT_W      = 5;
  localparam int FACE_W      = 3;
  localparam int OFS_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int AREA_W      = 2 * AXIS_W;

  typedef logic [AXIS_W-1:0]    axis_t;
  typedef logic [AREA_W-1:0]    area_t;
  typedef logic [COORD_W-1:0]   coord_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [FACE_W-1:0]    face_t;
  typedef logic [OFS_W-1:0]     ofs_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_GRID_X = 2'd0;
  localparam cfg_idx_t REG_GRID_Y = 2'd1;
  localparam cfg_idx_t REG_GRID_Z = 2'd2;

  // offset codes, value is offset plus one
  localparam ofs_t OFS_NEG  = 2'd0;
  localparam ofs_t OFS_ZERO = 2'd1;
  localparam ofs_t OFS_POS  = 2'd2;

  localparam face_t FACE_NEG_X = 3'd0;
  localparam face_t FACE_POS_X = 3'd1;
  localparam face_t FACE_NEG_Y = 3'd2;
  localparam face_t FACE_POS_Y = 3'd3;
  localparam face_t FACE_NEG_Z = 3'd4;
  localparam face_t FACE_POS_Z = 3'd5;
  localparam face_t FACE_NONE  = 3'd6;

  localparam slot_t SLOT_FIRST = 5'd0;
  localparam slot_t SLOT_SELF  = 5'd13;

  typedef struct packed {
    axis_t gx;
    axis_t gy;
    axis_t gz;
    area_t gxy;
  } grid_cfg_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    coord_t cz;
    logic   oor;
    slot_t  last_slot;
  } cell_job_t;

  function automatic axis_t sat_axis(input axis_t value);
    axis_t res;
    res = (value > axis_t'(AXIS_MAX)) ? axis_t'(AXIS_MAX) : value;
    return res;
  endfunction

  function automatic slot_t slot_of(input ofs_t dx, input ofs_t dy, input ofs_t dz);
    slot_t res;
    res = slot_t'(dx) * slot_t'(9) + slot_t'(dy) * slot_t'(3) + slot_t'(dz);
    return res;
  endfunction

  function automatic logic half_of(input ofs_t dx, input ofs_t dy, input ofs_t dz);
    logic self_hit;
    logic res;
    self_hit = (dx == OFS_ZERO) && (dy == OFS_ZERO) && (dz == OFS_ZERO);
    res = !self_hit && ((dy == OFS_POS) ||
                        (dy == OFS_ZERO && dz != OFS_NEG && dx != OFS_POS) ||
                        (dy == OFS_ZERO && dz == OFS_POS && dx == OFS_POS));
    return res;
  endfunction

  function automatic face_t face_of(input ofs_t dx, input ofs_t dy, input ofs_t dz);
    face_t res;
    if (dy == OFS_ZERO && dz == OFS_ZERO && dx != OFS_ZERO) begin
      res = (dx == OFS_NEG) ? FACE_NEG_X : FACE_POS_X;
    end else if (dx == OFS_ZERO && dz == OFS_ZERO && dy != OFS_ZERO) begin
      res = (dy == OFS_NEG) ? FACE_NEG_Y : FACE_POS_Y;
    end else if (dx == OFS_ZERO && dy == OFS_ZERO && dz != OFS_ZERO) begin
      res = (dz == OFS_NEG) ? FACE_NEG_Z : FACE_POS_Z;
    end else begin
      res = FACE_NONE;
    end
    return res;
  endfunction

endpackage

### design/gnsg_in_if.sv
// input channel: one centre cell per item
interface gnsg_in_if;
  logic            valid;
  logic            ready;
  gnsg_pkg::coord_t cell_x;
  gnsg_pkg::coord_t cell_y;
  gnsg_pkg::coord_t cell_z;

  modport source (output valid, output cell_x, output cell_y, output cell_z, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input cell_z, output ready);
endinterface

### design/gnsg_out_if.sv
// result channel: one neighbour per item
interface gnsg_out_if;
  logic             valid;
  logic             ready;
  gnsg_pkg::index_t neighbor_index;
  gnsg_pkg::slot_t  stencil_slot;
  logic             is_self;
  logic             half_shell;
  gnsg_pkg::face_t  face_direction;
  logic             out_of_range;
  logic             last_of_run;

  modport source (output valid, output neighbor_index, output stencil_slot, output is_self,
                  output half_shell, output face_direction, output out_of_range,
                  output last_of_run, input ready);
  modport sink   (input valid, input neighbor_index, input stencil_slot, input is_self,
                  input half_shell, input face_direction, input out_of_range,
                  input last_of_run, output ready);
endinterface

### design/gnsg_front.sv
// front end: grid size registers, range check and walk length of each centre cell
module gnsg_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  gnsg_pkg::cfg_idx_t     cfg_index,
  input  gnsg_pkg::axis_t        cfg_wdata,
  gnsg_in_if.sink                in_ch,
  output gnsg_pkg::grid_cfg_t    grid,
  output logic                   push_valid,
  output gnsg_pkg::cell_job_t    push_job,
  input  logic                   push_ready
);
  import gnsg_pkg::*;

  axis_t gx_r, gy_r, gz_r;
  area_t gxy_r;
  axis_t cx_w, cy_w, cz_w;
  ofs_t  xm, ym, zm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r <= axis_t'(1);
      gy_r <= axis_t'(1);
      gz_r <= axis_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_X: gx_r <= sat_axis(cfg_wdata);
        REG_GRID_Y: gy_r <= sat_axis(cfg_wdata);
        REG_GRID_Z: gz_r <= sat_axis(cfg_wdata);
        default: ;
      endcase
    end
  end

  // plane size, registered from the grid size registers
  always_ff @(posedge clk) begin
    gxy_r <= area_t'(gx_r) * area_t'(gy_r);
  end

  assign grid = '{gx: gx_r, gy: gy_r, gz: gz_r, gxy: gxy_r};

  always_comb begin
    cx_w = axis_t'(in_ch.cell_x);
    cy_w = axis_t'(in_ch.cell_y);
    cz_w = axis_t'(in_ch.cell_z);
    // highest offset per axis that stays inside the grid
    xm = (cx_w + axis_t'(1) < gx_r) ? OFS_POS : OFS_ZERO;
    ym = (cy_w + axis_t'(1) < gy_r) ? OFS_POS : OFS_ZERO;
    zm = (cz_w + axis_t'(1) < gz_r) ? OFS_POS : OFS_ZERO;
    push_job.cx        = in_ch.cell_x;
    push_job.cy        = in_ch.cell_y;
    push_job.cz        = in_ch.cell_z;
    push_job.oor       = (cx_w >= gx_r) || (cy_w >= gy_r) || (cz_w >= gz_r);
    push_job.last_slot = slot_of(xm, ym, zm);
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

endmodule

### design/gnsg_queue.sv
// short queue of classified cells between front end and walker
module gnsg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  gnsg_pkg::cell_job_t push_job,
  output logic                push_ready,
  output logic                pop_valid,
  output gnsg_pkg::cell_job_t pop_job,
  input  logic                pop_ready
);
  import gnsg_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  cell_job_t mem_r [QUEUE_DEPTH];
  ptr_t      wr_ptr_r, wr_ptr_nxt;
  ptr_t      rd_ptr_r, rd_ptr_nxt;
  cnt_t      count_r, count_nxt;
  logic      do_push, do_pop;

  assign push_ready = (count_r != cnt_t'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != cnt_t'(0));
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : wr_ptr_r + ptr_t'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == ptr_t'(QUEUE_DEPTH - 1)) ? ptr_t'(0) : rd_ptr_r + ptr_t'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + cnt_t'(1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == cnt_t'(0) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with empty count");
`endif

endmodule

### design/gnsg_back.sv
// back end: walks the offsets up to each cell's last slot, drops outside neighbours, builds the flat index
module gnsg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  gnsg_pkg::grid_cfg_t grid,
  input  logic                pop_valid,
  input  gnsg_pkg::cell_job_t pop_job,
  output logic                pop_ready,
  gnsg_out_if.source          out_ch
);
  import gnsg_pkg::*;

  localparam int NW    = AXIS_W + 1;
  localparam int PY_W  = 2 * AXIS_W;
  localparam int PZ_W  = AXIS_W + AREA_W;
  localparam int SUM_W = PZ_W + 1;

  typedef logic [NW-1:0] ncoord_t;

  // walker
  logic      busy_r, busy_nxt;
  cell_job_t job_r, job_nxt;
  ofs_t      dx_r, dx_nxt, dy_r, dy_nxt, dz_r, dz_nxt;
  slot_t     slot_r, slot_nxt;

  // stage 1: products
  logic             s1_valid_r;
  axis_t            s1_nx_r;
  logic [PY_W-1:0]  s1_py_r;
  logic [PZ_W-1:0]  s1_pz_r;
  slot_t            s1_slot_r;
  logic             s1_self_r, s1_half_r, s1_oor_r, s1_last_r;
  face_t            s1_face_r;

  // output register
  logic   out_valid_r;
  index_t out_index_r;
  slot_t  out_slot_r;
  logic   out_self_r, out_half_r, out_oor_r, out_last_r;
  face_t  out_face_r;

  ncoord_t nx, ny, nz;
  logic    in_grid, finish, advance, step, emit, take;
  logic [SUM_W-1:0] sum_w;

  assign advance = !out_valid_r || out_ch.ready;
  assign step    = busy_r && advance;

  always_comb begin
    nx = ncoord_t'(job_r.cx) + ncoord_t'(dx_r) - ncoord_t'(1);
    ny = ncoord_t'(job_r.cy) + ncoord_t'(dy_r) - ncoord_t'(1);
    nz = ncoord_t'(job_r.cz) + ncoord_t'(dz_r) - ncoord_t'(1);
    // a borrow into the top bit marks a coordinate below zero
    in_grid = !nx[NW-1] && !ny[NW-1] && !nz[NW-1] &&
              (nx[AXIS_W-1:0] < grid.gx) && (ny[AXIS_W-1:0] < grid.gy) &&
              (nz[AXIS_W-1:0] < grid.gz);
    finish  = job_r.oor || (slot_r == job_r.last_slot);
    emit    = step && (job_r.oor || in_grid);
    take    = pop_valid && (!busy_r || (step && finish));
  end

  assign pop_ready = take;

  always_comb begin
    busy_nxt = busy_r;
    job_nxt  = job_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    dz_nxt   = dz_r;
    slot_nxt = slot_r;
    priority if (take) begin
      busy_nxt = 1'b1;
      job_nxt  = pop_job;
      dx_nxt   = OFS_NEG;
      dy_nxt   = OFS_NEG;
      dz_nxt   = OFS_NEG;
      slot_nxt = SLOT_FIRST;
    end else if (step && finish) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      slot_nxt = slot_r + slot_t'(1);
      if (dz_r != OFS_POS) begin
        dz_nxt = dz_r + ofs_t'(1);
      end else begin
        dz_nxt = OFS_NEG;
        if (dy_r != OFS_POS) begin
          dy_nxt = dy_r + ofs_t'(1);
        end else begin
          dy_nxt = OFS_NEG;
          dx_nxt = dx_r + ofs_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= SLOT_FIRST;
    end else begin
      busy_r <= busy_nxt;
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    dx_r  <= dx_nxt;
    dy_r  <= dy_nxt;
    dz_r  <= dz_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= emit;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (job_r.oor) begin
        s1_nx_r   <= '0;
        s1_py_r   <= '0;
        s1_pz_r   <= '0;
        s1_slot_r <= SLOT_FIRST;
        s1_self_r <= 1'b0;
        s1_half_r <= 1'b0;
        s1_face_r <= FACE_NONE;
        s1_oor_r  <= 1'b1;
      end else begin
        s1_nx_r   <= nx[AXIS_W-1:0];
        s1_py_r   <= PY_W'(ny[AXIS_W-1:0]) * PY_W'(grid.gx);
        s1_pz_r   <= PZ_W'(nz[AXIS_W-1:0]) * PZ_W'(grid.gxy);
        s1_slot_r <= slot_r;
        s1_self_r <= (slot_r == SLOT_SELF);
        s1_half_r <= half_of(dx_r, dy_r, dz_r);
        s1_face_r <= face_of(dx_r, dy_r, dz_r);
        s1_oor_r  <= 1'b0;
      end
      s1_last_r <= finish;
    end
  end

  assign sum_w = SUM_W'(s1_nx_r) + SUM_W'(s1_py_r) + SUM_W'(s1_pz_r);

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index_r <= sum_w[INDEX_W-1:0];
      out_slot_r  <= s1_slot_r;
      out_self_r  <= s1_self_r;
      out_half_r  <= s1_half_r;
      out_face_r  <= s1_face_r;
      out_oor_r   <= s1_oor_r;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.neighbor_index = out_index_r;
  assign out_ch.stencil_slot   = out_slot_r;
  assign out_ch.is_self        = out_self_r;
  assign out_ch.half_shell     = out_half_r;
  assign out_ch.face_direction = out_face_r;
  assign out_ch.out_of_range   = out_oor_r;
  assign out_ch.last_of_run    = out_last_r;

`ifndef SYNTHESIS
  a_oor_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_last_r && out_face_r == FACE_NONE &&
                                 out_index_r == '0)
    else $error("out of range item not a lone result");
  a_self_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_self_r |-> out_slot_r == SLOT_SELF && !out_half_r &&
                                  out_face_r == FACE_NONE)
    else $error("centre result with wrong flags");
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !job_r.oor |-> slot_r <= job_r.last_slot)
    else $error("walk ran past its last slot");
  a_no_early_take: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !finish |-> !take)
    else $error("next cell taken before walk finished");
`endif

endmodule

### design/grid_neighbor_stencil_generator.sv
// top level of the 27-point neighbour stencil generator
// path: with the walker idle an accepted cell passes the queue, the walker's job register,
//   stage 1 and the output register, after any leading slots outside the grid (up to 13)
// throughput: at most one result per cycle, held while the receiver stalls; a cell in range is
//   walked one slot at a time up to its last in-grid slot (14 to 27 slots), one out of range gives one result
// reset: synchronous, active low; grid sizes return to 1, queue and walker empty
module grid_neighbor_stencil_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  gnsg_pkg::cfg_idx_t cfg_index,
  input  gnsg_pkg::axis_t    cfg_wdata,
  gnsg_in_if.sink            in_ch,
  gnsg_out_if.source         out_ch
);
  import gnsg_pkg::*;

  grid_cfg_t grid;
  logic      push_valid, push_ready, pop_valid, pop_ready;
  cell_job_t push_job, pop_job;

  gnsg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .grid       (grid),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready)
  );

  gnsg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_job   (push_job),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job),
    .pop_ready  (pop_ready)
  );

  gnsg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid      (grid),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .pop_ready (pop_ready),
    .out_ch    (out_ch)
  );

endmodule

### bench/stencil_check_pkg.sv
// scoreboard of the neighbour stencil generator bench: grid mirror, neighbour predictor, checks
`timescale 1ns / 100ps
package stencil_check_pkg;
  import gnsg_pkg::*;

  // index that selects no register
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    index_t idx;
    slot_t  slot;
    logic   self;
    logic   half;
    face_t  face;
    logic   oor;
    logic   last;
  } neighbor_t;

  class neighbor_checker;
    int        size_x = 1;
    int        size_y = 1;
    int        size_z = 1;
    int        failures = 0;
    neighbor_t expected_neighbors[$];

    function void set_size(cfg_idx_t reg_idx, axis_t value);
      int sat;
      sat = (value > AXIS_MAX) ? AXIS_MAX : int'(value);
      case (reg_idx)
        REG_GRID_X: size_x = sat;
        REG_GRID_Y: size_y = sat;
        REG_GRID_Z: size_z = sat;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_neighbors.size();
    endfunction

    // walk the 27 offsets of one accepted cell, dx slowest and dz fastest; a cell out of range gives one result
    function void note_cell(coord_t cx, coord_t cy, coord_t cz);
      neighbor_t r;
      int        nx, ny, nz;
      int        slot;
      int        nonzero;
      if (cx >= size_x || cy >= size_y || cz >= size_z) begin
        r = '0;
        r.face = FACE_NONE;
        r.oor = 1'b1;
        r.last = 1'b1;
        expected_neighbors = {expected_neighbors, r};
        return;
      end
      slot = 0;
      for (int dx = -1; dx <= 1; dx++) begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dz = -1; dz <= 1; dz++) begin
            nx = int'(cx) + dx;
            ny = int'(cy) + dy;
            nz = int'(cz) + dz;
            if (nx >= 0 && ny >= 0 && nz >= 0 &&
                nx < size_x && ny < size_y && nz < size_z) begin
              r = '0;
              r.idx = index_t'(nx + ny * size_x + nz * size_x * size_y);
              r.slot = slot_t'(slot);
              r.self = (dx == 0 && dy == 0 && dz == 0);
              if (dy == 1)
                r.half = 1'b1;
              else if (dy == 0)
                r.half = (dx <= 0 && dz >= 0) || (dx == 1 && dz == 1);
              r.half = r.half && !r.self;
              nonzero = (dx != 0) + (dy != 0) + (dz != 0);
              if (nonzero != 1)
                r.face = FACE_NONE;
              else if (dx != 0)
                r.face = (dx < 0) ? FACE_NEG_X : FACE_POS_X;
              else if (dy != 0)
                r.face = (dy < 0) ? FACE_NEG_Y : FACE_POS_Y;
              else
                r.face = (dz < 0) ? FACE_NEG_Z : FACE_POS_Z;
              expected_neighbors = {expected_neighbors, r};
            end
            slot++;
          end
        end
      end
      // the centre always lies inside, so this run has at least one entry
      expected_neighbors[expected_neighbors.size() - 1].last = 1'b1;
    endfunction

    function void check_result(neighbor_t got);
      neighbor_t want;
      if (expected_neighbors.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("extra result: idx=%0d slot=%0d self=%0b half=%0b face=%0d oor=%0b last=%0b",
                   got.idx, got.slot, got.self, got.half, got.face, got.oor, got.last);
        return;
      end
      want = expected_neighbors.pop_front();
      if (got.idx !== want.idx || got.slot !== want.slot || got.self !== want.self ||
          got.half !== want.half || got.face !== want.face || got.oor !== want.oor ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("exp idx=%0d slot=%0d self=%0b half=%0b face=%0d oor=%0b last=%0b",
                   want.idx, want.slot, want.self, want.half, want.face, want.oor, want.last);
          $display("got idx=%0d slot=%0d self=%0b half=%0b face=%0d oor=%0b last=%0b",
                   got.idx, got.slot, got.self, got.half, got.face, got.oor, got.last);
        end
      end
    endfunction
  endclass

endpackage

### bench/tb_top.sv
// top of the neighbour stencil generator bench: clock, reset, stimulus and result monitor
`timescale 1ns / 100ps
module tb_top;
  import gnsg_pkg::*;
  import stencil_check_pkg::*;

  localparam int CYCLE_LIMIT = 500000;

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_index;
  axis_t    cfg_wdata;
  int       cycle_count = 0;

  neighbor_checker sb;

  gnsg_in_if  in_ch();
  gnsg_out_if out_ch();

  grid_neighbor_stencil_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("grid_neighbor_stencil_generator: mismatch");
    $finish;
  end

  // receiver stalls follow a mode taken from the cycle counter shifted right by 7
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case ((cycle_count >> 7) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= (cycle_count % 3 == 0);
        default: out_ch.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    neighbor_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.idx = out_ch.neighbor_index;
      got.slot = out_ch.stencil_slot;
      got.self = out_ch.is_self;
      got.half = out_ch.half_shell;
      got.face = out_ch.face_direction;
      got.oor = out_ch.out_of_range;
      got.last = out_ch.last_of_run;
      sb.check_result(got);
    end
  end

  task automatic send_cell(coord_t x, coord_t y, coord_t z);
    in_ch.valid <= 1'b1;
    in_ch.cell_x <= x;
    in_ch.cell_y <= y;
    in_ch.cell_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_cell(x, y, z);
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic lower_and_drain();
    in_ch.valid <= 1'b0;
    drain();
  endtask

  task automatic write_reg(cfg_idx_t reg_idx, axis_t value);
    cfg_we <= 1'b1;
    cfg_index <= reg_idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_size(reg_idx, value);
  endtask

  // only called with the block idle
  task automatic set_grid(axis_t gx, axis_t gy, axis_t gz, bit junk);
    write_reg(REG_GRID_X, gx);
    write_reg(REG_GRID_Y, gy);
    if (junk) write_reg(REG_UNUSED, axis_t'($urandom_range(0, 127)));
    write_reg(REG_GRID_Z, gz);
    cfg_we <= 1'b0;
  endtask

  function automatic axis_t pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 13) return axis_t'(1);
    if (r < 25) return axis_t'(AXIS_MAX);
    if (r < 30) return axis_t'($urandom_range(AXIS_MAX + 1, 127));
    if (r < 75) return axis_t'($urandom_range(2, 8));
    return axis_t'($urandom_range(1, AXIS_MAX));
  endfunction

  // mostly inside the grid, with a bias towards the faces
  function automatic coord_t pick_coord(int size);
    int r;
    r = $urandom_range(0, 99);
    if (size == 0 || r < 5) return coord_t'($urandom_range(0, 63));
    if (r < 18) return '0;
    if (r < 31) return coord_t'(size - 1);
    return coord_t'($urandom_range(0, size - 1));
  endfunction

  task automatic run_cells(int n, bit calm);
    int sent;
    int burst;
    int gap;
    bit hold;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_cell(pick_coord(sb.size_x), pick_coord(sb.size_y), pick_coord(sb.size_z));
        sent++;
      end
      hold = !calm && ($urandom_range(0, 15) == 0);
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0 || hold || sent >= n) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        if (hold) drain();
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_GRID_X;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.cell_x <= '0;
    in_ch.cell_y <= '0;
    in_ch.cell_z <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset grid of one cell: only the centre itself, anything else out of range
    send_cell(0, 0, 0);
    send_cell(1, 0, 0);
    send_cell(0, 0, 63);
    lower_and_drain();

    // zero-sized axis rejects every cell
    set_grid(0, 1, 1, 1'b0);
    send_cell(0, 0, 0);
    lower_and_drain();

    // oversized writes saturate to the full grid, junk index ignored
    set_grid(100, 127, AXIS_MAX, 1'b1);
    send_cell(0, 0, 0);
    send_cell(63, 63, 63);
    send_cell(31, 17, 42);
    send_cell(63, 0, 0);
    send_cell(0, 63, 0);
    send_cell(0, 0, 63);
    lower_and_drain();

    // small cube: full stencil in the middle, corners and just outside
    set_grid(3, 3, 3, 1'b1);
    send_cell(1, 1, 1);
    send_cell(0, 0, 0);
    send_cell(2, 2, 2);
    send_cell(3, 1, 1);
    send_cell(1, 1, 3);
    lower_and_drain();

    set_grid(2, 1, 5, 1'b0);
    send_cell(1, 0, 4);
    send_cell(0, 0, 2);
    lower_and_drain();

    for (int p = 0; p < 6; p++) begin
      set_grid(pick_size(), pick_size(), pick_size(), bit'($urandom_range(0, 1)));
      run_cells(42, p % 2 == 1);
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("grid_neighbor_stencil_generator: match");
    else
      $display("grid_neighbor_stencil_generator: mismatch");
    $finish;
  end

endmodule

### grid_neighbor_stencil_generator.f
design/gnsg_pkg.sv
design/gnsg_in_if.sv
design/gnsg_out_if.sv
design/gnsg_front.sv
design/gnsg_queue.sv
design/gnsg_back.sv
design/grid_neighbor_stencil_generator.sv
bench/stencil_check_pkg.sv
bench/tb_top.sv
